### hdl/ppsa_pkg.sv
// Shared types, widths and codes of the preemptive priority scheduler with aging.
package ppsa_pkg;

    localparam int MAX_TASKS_DEF = 64;

    localparam int ARR_W  = 10;
    localparam int PRI_W  = 8;
    localparam int RUN_W  = 4;
    localparam int WAIT_W = 5;
    localparam int TICK_W = 12;
    localparam int ID_W   = 7;

    localparam logic [WAIT_W-1:0] THR_RESET = 5'd20;
    localparam logic [WAIT_W-1:0] WAIT_MAX  = 5'd31;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // One row of the task table.
    typedef struct packed {
        logic [ARR_W-1:0]  arr;
        logic [PRI_W-1:0]  pri;
        logic [RUN_W-1:0]  rem;
        logic [WAIT_W-1:0] wt;
    } t_entry;

    // Context that the sequencer hands to the entry unit for each row.
    typedef struct packed {
        logic              found;
        logic              is_chosen;
        logic [TICK_W-1:0] now;
        logic [WAIT_W-1:0] thr;
        logic [PRI_W-1:0]  best_pri;
    } t_alu_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SELECT,
        ST_UPDATE,
        ST_REPORT
    } t_state;

endpackage

### hdl/ppsa_if.sv
// Channel interfaces of the scheduler: task input, tick result and threshold write.
interface ppsa_in_if import ppsa_pkg::*;;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ARR_W-1:0]  arrival_time;
    logic [PRI_W-1:0]  priority_level;
    logic [RUN_W-1:0]  run_length;

    modport source(output valid, cmd, arrival_time, priority_level, run_length,
                   input ready);
    modport sink(input valid, cmd, arrival_time, priority_level, run_length,
                 output ready);
endinterface

interface ppsa_out_if import ppsa_pkg::*;;
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] tick_time;
    logic              idle;
    logic [ID_W-1:0]   task_id;
    logic              finished;
    logic [TICK_W-1:0] turnaround;
    logic              all_done;

    modport source(output valid, tick_time, idle, task_id, finished, turnaround,
                   all_done, input ready);
    modport sink(input valid, tick_time, idle, task_id, finished, turnaround,
                 all_done, output ready);
endinterface

interface ppsa_cfg_if import ppsa_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WAIT_W-1:0] data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

### hdl/preemptive_priority_scheduler_aging.sv
// Top level of the preemptive priority scheduler with aging: sequencer and registers.
//
// Usage: items arrive on i_task. A load transaction (cmd = 0) appends a task to the
// table and gives no result; it is dropped when the table is full. A
// tick transaction (cmd = 1) gives exactly one result on o_res: the task served in
// this tick (or idle), its completion and turnaround, and the all-done flag.
// A tick walks the table twice through the single memory read port: one pass picks
// the task to serve, the second serves it, counts waits and ages priorities. The
// result is registered in ST_REPORT after both passes. A tick holds the input
// through both passes and the report; i_task is not ready until ST_IDLE again.
// The result sits in an output register. Loads are taken while it waits; a later
// tick finishes its passes and then holds until the receiver takes the earlier one.
// i_cfg writes the aging threshold and is always ready; write it only when idle.
// Reset (synchronous, active low) empties the table, zeroes the tick counter and
// sets the threshold to 20. No clearing pass is needed: only loaded rows are read.
module preemptive_priority_scheduler_aging import ppsa_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ppsa_cfg_if.sink     i_cfg,
    ppsa_in_if.sink      i_task,
    ppsa_out_if.source   o_res
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_loaded, n_loaded;
    logic [CW-1:0]     r_done, n_done;
    logic [TICK_W-1:0] r_now, n_now;
    logic [WAIT_W-1:0] r_thr;
    logic [CW-1:0]     r_issue, n_issue;
    logic              r_dv, n_dv;
    logic [IW-1:0]     r_didx, n_didx;
    logic              r_found, n_found;
    logic [IW-1:0]     r_chosen, n_chosen;
    logic [PRI_W-1:0]  r_best_pri, n_best_pri;
    logic [ARR_W-1:0]  r_best_arr, n_best_arr;
    logic [RUN_W-1:0]  r_best_rem, n_best_rem;
    logic              r_ov, n_ov;
    logic [TICK_W-1:0] r_o_tick, n_o_tick;
    logic              r_o_idle, n_o_idle;
    logic [ID_W-1:0]   r_o_id, n_o_id;
    logic              r_o_fin, n_o_fin;
    logic [TICK_W-1:0] r_o_turn, n_o_turn;
    logic              r_o_all, n_o_all;

    logic          mem_we;
    logic [IW-1:0] mem_wr_addr;
    t_entry        mem_wr_data;
    logic          mem_rd_en;
    t_entry        mem_rd_data;

    t_alu_ctl      alu_ctl;
    logic          alu_better;
    t_entry        alu_upd;

    logic          task_acc;
    logic          fin;
    logic [CW-1:0] done_tick;

    ppsa_mem #(
        .MAX_TASKS (MAX_TASKS),
        .IW        (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_issue[IW-1:0]),
        .o_rd_data (mem_rd_data)
    );

    ppsa_alu u_alu (
        .i_entry  (mem_rd_data),
        .i_ctl    (alu_ctl),
        .o_better (alu_better),
        .o_upd    (alu_upd)
    );

    assign i_cfg.ready  = 1'b1;
    assign i_task.ready = (r_state == ST_IDLE);
    assign task_acc     = i_task.valid && i_task.ready;

    assign o_res.valid      = r_ov;
    assign o_res.tick_time  = r_o_tick;
    assign o_res.idle       = r_o_idle;
    assign o_res.task_id    = r_o_id;
    assign o_res.finished   = r_o_fin;
    assign o_res.turnaround = r_o_turn;
    assign o_res.all_done   = r_o_all;

    always_comb begin
        alu_ctl.found     = r_found;
        alu_ctl.is_chosen = r_found && (r_didx == r_chosen);
        alu_ctl.now       = r_now;
        alu_ctl.thr       = r_thr;
        alu_ctl.best_pri  = r_best_pri;
    end

    assign fin       = r_found && (r_best_rem == RUN_W'(1));
    assign done_tick = r_done + CW'(fin);

    always_comb begin
        n_state    = r_state;
        n_loaded   = r_loaded;
        n_done     = r_done;
        n_now      = r_now;
        n_issue    = r_issue;
        n_dv       = 1'b0;
        n_didx     = r_issue[IW-1:0];
        n_found    = r_found;
        n_chosen   = r_chosen;
        n_best_pri = r_best_pri;
        n_best_arr = r_best_arr;
        n_best_rem = r_best_rem;
        n_ov       = r_ov && !o_res.ready;
        n_o_tick   = r_o_tick;
        n_o_idle   = r_o_idle;
        n_o_id     = r_o_id;
        n_o_fin    = r_o_fin;
        n_o_turn   = r_o_turn;
        n_o_all    = r_o_all;

        mem_we      = 1'b0;
        mem_wr_addr = r_didx;
        mem_wr_data = alu_upd;
        mem_rd_en   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (task_acc) begin
                    if (i_task.cmd == CMD_LOAD) begin
                        if (r_loaded != CW'(MAX_TASKS)) begin
                            mem_we          = 1'b1;
                            mem_wr_addr     = r_loaded[IW-1:0];
                            mem_wr_data.arr = i_task.arrival_time;
                            mem_wr_data.pri = i_task.priority_level;
                            mem_wr_data.rem = i_task.run_length;
                            mem_wr_data.wt  = '0;
                            n_loaded        = r_loaded + CW'(1);
                            // A task with no work is complete the moment it is loaded.
                            if (i_task.run_length == '0) begin
                                n_done = r_done + CW'(1);
                            end
                        end
                    end else begin
                        n_issue = '0;
                        n_found = 1'b0;
                        n_state = ST_SELECT;
                    end
                end
            end

            ST_SELECT: begin
                mem_rd_en = (r_issue < r_loaded);
                n_dv      = mem_rd_en;
                if (mem_rd_en) begin
                    n_issue = r_issue + CW'(1);
                end
                if (r_dv && alu_better) begin
                    n_found    = 1'b1;
                    n_chosen   = r_didx;
                    n_best_pri = mem_rd_data.pri;
                    n_best_arr = mem_rd_data.arr;
                    n_best_rem = mem_rd_data.rem;
                end
                if (!mem_rd_en && !r_dv) begin
                    n_issue = '0;
                    n_state = ST_UPDATE;
                end
            end

            ST_UPDATE: begin
                mem_rd_en = (r_issue < r_loaded);
                n_dv      = mem_rd_en;
                if (mem_rd_en) begin
                    n_issue = r_issue + CW'(1);
                end
                // Write back the row read in the previous cycle.
                mem_we = r_dv;
                if (!mem_rd_en && !r_dv) begin
                    n_state = ST_REPORT;
                end
            end

            ST_REPORT: begin
                if (!r_ov || o_res.ready) begin
                    n_ov     = 1'b1;
                    n_o_tick = r_now;
                    n_o_idle = !r_found;
                    n_o_id   = r_found ? ID_W'({1'b0, r_chosen} + (IW + 1)'(1)) : '0;
                    n_o_fin  = fin;
                    n_o_turn = fin ? (r_now + TICK_W'(1) - TICK_W'(r_best_arr)) : '0;
                    n_o_all  = (done_tick == r_loaded);
                    n_done   = done_tick;
                    n_now    = r_now + TICK_W'(1);
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_loaded <= '0;
            r_done   <= '0;
            r_now    <= '0;
            r_thr    <= THR_RESET;
            r_issue  <= '0;
            r_dv     <= 1'b0;
            r_found  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_done   <= n_done;
            r_now    <= n_now;
            r_issue  <= n_issue;
            r_dv     <= n_dv;
            r_found  <= n_found;
            r_ov     <= n_ov;
            if (i_cfg.valid && i_cfg.ready) begin
                r_thr <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx     <= n_didx;
        r_chosen   <= n_chosen;
        r_best_pri <= n_best_pri;
        r_best_arr <= n_best_arr;
        r_best_rem <= n_best_rem;
        r_o_tick   <= n_o_tick;
        r_o_idle   <= n_o_idle;
        r_o_id     <= n_o_id;
        r_o_fin    <= n_o_fin;
        r_o_turn   <= n_o_turn;
        r_o_all    <= n_o_all;
    end

endmodule

### hdl/ppsa_mem.sv
// Task table memory: one write port and one registered read port.
module ppsa_mem import ppsa_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int IW        = $clog2(MAX_TASKS)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [MAX_TASKS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/ppsa_alu.sv
// Shared per-row unit: readiness and priority compare, then service, wait and aging update.
module ppsa_alu import ppsa_pkg::*; (
    input  t_entry   i_entry,
    input  t_alu_ctl i_ctl,
    output logic     o_better,
    output t_entry   o_upd
);

    logic              rdy;
    logic [WAIT_W-1:0] thr_eff;
    logic [WAIT_W-1:0] wt_new;
    logic [RUN_W-1:0]  rem_new;

    always_comb begin
        rdy      = ({{(TICK_W-ARR_W){1'b0}}, i_entry.arr} <= i_ctl.now) &&
                   (i_entry.rem != '0);
        o_better = rdy && (!i_ctl.found || (i_entry.pri < i_ctl.best_pri));

        // A threshold of zero behaves as a threshold of one.
        thr_eff  = (i_ctl.thr == '0) ? WAIT_W'(1) : i_ctl.thr;

        if (i_ctl.is_chosen) begin
            rem_new = i_entry.rem - RUN_W'(1);
            wt_new  = '0;
        end else begin
            rem_new = i_entry.rem;
            if (i_ctl.found && rdy && (i_entry.wt != WAIT_MAX)) begin
                wt_new = i_entry.wt + WAIT_W'(1);
            end else begin
                wt_new = i_entry.wt;
            end
        end

        o_upd     = i_entry;
        o_upd.rem = rem_new;
        o_upd.wt  = wt_new;
        if ((rem_new != '0) && (wt_new >= thr_eff)) begin
            if (i_entry.pri != '0) begin
                o_upd.pri = i_entry.pri - PRI_W'(1);
            end
            o_upd.wt = '0;
        end
    end

endmodule

### tb/tb_preemptive_priority_scheduler_aging.sv
// Testbench of the priority scheduler: directed and random loads and ticks against a model.
`timescale 1ns / 100ps

module tb_preemptive_priority_scheduler_aging import ppsa_pkg::*;;

    localparam int SLOTS       = MAX_TASKS_DEF;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [TICK_W-1:0] tick_time;
        logic              idle;
        logic [ID_W-1:0]   task_id;
        logic              finished;
        logic [TICK_W-1:0] turnaround;
        logic              all_done;
    } t_sched_report;

    logic i_clk;
    logic i_rst_n;

    ppsa_cfg_if cfg_ch();
    ppsa_in_if  task_ch();
    ppsa_out_if res_ch();

    preemptive_priority_scheduler_aging #(
        .MAX_TASKS(SLOTS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_task (task_ch),
        .o_res  (res_ch)
    );

    // Shadow copy of the task table and scheduler state.
    logic [ARR_W-1:0]  tbl_arrival   [SLOTS];
    logic [PRI_W-1:0]  tbl_priority  [SLOTS];
    logic [RUN_W-1:0]  tbl_remaining [SLOTS];
    logic [WAIT_W-1:0] tbl_wait      [SLOTS];
    int                tbl_loaded;
    int                tbl_done;
    logic [TICK_W-1:0] cur_tick;
    logic [WAIT_W-1:0] aging_thr;

    t_sched_report expected_reports[$];
    int            err_count;
    int            cycle_count;
    logic          no_gaps;

    always #2 i_clk = ~i_clk;

    function automatic logic task_ready(int idx);
        return ({2'b00, tbl_arrival[idx]} <= cur_tick) && (tbl_remaining[idx] != 0);
    endfunction

    function automatic void record_load(logic [ARR_W-1:0] arr, logic [PRI_W-1:0] pri,
                                        logic [RUN_W-1:0] run);
        if (tbl_loaded < SLOTS) begin
            tbl_arrival[tbl_loaded]   = arr;
            tbl_priority[tbl_loaded]  = pri;
            tbl_remaining[tbl_loaded] = run;
            tbl_wait[tbl_loaded]      = '0;
            tbl_loaded++;
            if (run == 0) begin
                tbl_done++;
            end
        end
    endfunction

    function automatic t_sched_report schedule_tick();
        t_sched_report     rep;
        logic              found;
        int                chosen;
        logic [WAIT_W-1:0] thr;

        found  = 1'b0;
        chosen = 0;
        rep    = '0;
        for (int i = 0; i < tbl_loaded; i++) begin
            if (task_ready(i) && (!found || tbl_priority[i] < tbl_priority[chosen])) begin
                chosen = i;
                found  = 1'b1;
            end
        end

        if (found) begin
            tbl_remaining[chosen]--;
            for (int i = 0; i < tbl_loaded; i++) begin
                if (i != chosen && task_ready(i) && tbl_wait[i] < WAIT_MAX) begin
                    tbl_wait[i]++;
                end
            end
            tbl_wait[chosen] = '0;
        end

        // Aging also reaches unfinished tasks that are not ready at the moment.
        thr = (aging_thr == 0) ? WAIT_W'(1) : aging_thr;
        for (int i = 0; i < tbl_loaded; i++) begin
            if (tbl_remaining[i] != 0 && tbl_wait[i] >= thr) begin
                if (tbl_priority[i] != 0) begin
                    tbl_priority[i]--;
                end
                tbl_wait[i] = '0;
            end
        end

        if (found && tbl_remaining[chosen] == 0) begin
            rep.finished   = 1'b1;
            rep.turnaround = cur_tick + TICK_W'(1) - {2'b00, tbl_arrival[chosen]};
            tbl_done++;
        end

        rep.tick_time = cur_tick;
        rep.idle      = !found;
        rep.task_id   = found ? ID_W'(chosen + 1) : '0;
        rep.all_done  = (tbl_done == tbl_loaded);
        cur_tick      = cur_tick + TICK_W'(1);
        return rep;
    endfunction

    task automatic issue_item(logic cmd, logic [ARR_W-1:0] arr, logic [PRI_W-1:0] pri,
                              logic [RUN_W-1:0] run);
        while (!no_gaps && $urandom_range(99) < 35) begin
            task_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        task_ch.valid          <= 1'b1;
        task_ch.cmd            <= cmd;
        task_ch.arrival_time   <= arr;
        task_ch.priority_level <= pri;
        task_ch.run_length     <= run;
        do @(posedge i_clk); while (!task_ch.ready);
        if (cmd == CMD_TICK) begin
            expected_reports.push_back(schedule_tick());
        end else begin
            record_load(arr, pri, run);
        end
    endtask

    task automatic issue_load(logic [ARR_W-1:0] arr, logic [PRI_W-1:0] pri,
                              logic [RUN_W-1:0] run);
        issue_item(CMD_LOAD, arr, pri, run);
    endtask

    // The payload of a tick is ignored by the block, so it carries noise.
    task automatic issue_tick();
        issue_item(CMD_TICK, ARR_W'($urandom), PRI_W'($urandom), RUN_W'($urandom));
    endtask

    task automatic wait_idle();
        task_ch.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [WAIT_W-1:0] thr);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= thr;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        aging_thr = thr;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : report_checker
        t_sched_report want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_reports.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result: expected none, actual tick %0d task %0d",
                         $time, res_ch.tick_time, res_ch.task_id);
            end else begin
                want = expected_reports.pop_front();
                check_field("tick_time", want.tick_time, res_ch.tick_time);
                check_field("idle", want.idle, res_ch.idle);
                check_field("task_id", want.task_id, res_ch.task_id);
                check_field("finished", want.finished, res_ch.finished);
                check_field("turnaround", want.turnaround, res_ch.turnaround);
                check_field("all_done", want.all_done, res_ch.all_done);
            end
        end
    end

    always @(posedge i_clk) begin
        res_ch.ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 35);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("tb_preemptive_priority_scheduler_aging: FAIL");
            $finish;
        end
    end

    task automatic test_empty_table();
        repeat (2) issue_tick();
    endtask

    // Field extremes, a tie at equal priority, a zero-length task and a late arrival.
    task automatic test_load_extremes();
        write_threshold(WAIT_MAX);
        issue_load(10'd0, 8'd0, 4'd1);
        issue_load(10'd0, 8'd255, 4'd15);
        issue_load(10'd0, 8'd255, 4'd2);
        issue_load(10'd1023, 8'd128, 4'd15);
        issue_load(10'd5, 8'd0, 4'd0);
        issue_load(10'd3, 8'd10, 4'd4);
        issue_load(10'd0, 8'd1, 4'd15);
        issue_load(10'd0, 8'd2, 4'd15);
        repeat (10) issue_tick();
    endtask

    // Waiting tasks already hold more ticks than the lowered threshold.
    task automatic test_threshold_changes();
        write_threshold(5'd3);
        repeat (5) issue_tick();
        write_threshold(5'd0);
        repeat (3) issue_tick();
        write_threshold(THR_RESET);
    endtask

    task automatic test_random_traffic();
        int               counted;
        int               near_arr;
        logic [WAIT_W-1:0] thr;
        logic [ARR_W-1:0]  arr;
        logic [PRI_W-1:0]  pri;
        logic [RUN_W-1:0]  run;

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: thr = 5'd1;
                1: thr = WAIT_MAX;
                2: thr = 5'd0;
                default: thr = WAIT_W'($urandom_range(0, 31));
            endcase
            write_threshold(thr);
            no_gaps = (phase == 3);
            counted = 0;
            while (counted < 100) begin
                if ($urandom_range(99) < 30) begin
                    near_arr = int'(cur_tick) + $urandom_range(0, 24);
                    case ($urandom_range(3))
                        0: arr = '0;
                        1: arr = ARR_W'($urandom_range(0, 1023));
                        default: arr = (near_arr > 1023) ? ARR_W'($urandom_range(0, 1023))
                                                         : ARR_W'(near_arr);
                    endcase
                    pri = $urandom_range(1) ? PRI_W'($urandom_range(0, 255))
                                            : PRI_W'($urandom_range(0, 3));
                    run = ($urandom_range(9) == 0) ? RUN_W'(0) : RUN_W'($urandom_range(1, 15));
                    // Loads into a full table are dropped and do not count.
                    if (tbl_loaded < SLOTS) begin
                        counted++;
                    end
                    issue_load(arr, pri, run);
                end else begin
                    issue_tick();
                    counted++;
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        i_clk                  = 1'b0;
        i_rst_n                = 1'b0;
        no_gaps                = 1'b0;
        err_count              = 0;
        cycle_count            = 0;
        tbl_loaded             = 0;
        tbl_done               = 0;
        cur_tick               = '0;
        aging_thr              = THR_RESET;
        cfg_ch.valid           = 1'b0;
        cfg_ch.data            = '0;
        task_ch.valid          = 1'b0;
        task_ch.cmd            = CMD_LOAD;
        task_ch.arrival_time   = '0;
        task_ch.priority_level = '0;
        task_ch.run_length     = '0;
        res_ch.ready           = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_wait[i] = '0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_load_extremes();
        test_threshold_changes();
        test_random_traffic();

        wait_idle();
        repeat (2 * SLOTS + 16) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_preemptive_priority_scheduler_aging: PASS");
        end else begin
            $display("tb_preemptive_priority_scheduler_aging: FAIL");
        end
        $finish;
    end

endmodule

### preemptive_priority_scheduler_aging.f
hdl/ppsa_pkg.sv
hdl/ppsa_if.sv
hdl/ppsa_mem.sv
hdl/ppsa_alu.sv
hdl/preemptive_priority_scheduler_aging.sv
tb/tb_preemptive_priority_scheduler_aging.sv
